// ===== rtl/core/cfc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 update for the frame checker.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned WINDOW_W   = 32;
  localparam int unsigned VERDICT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [WORD_W-1:0]  CRC_INIT       = 16'hFFFF;
  localparam logic [WORD_W-1:0]  CRC_POLY       = 16'hA001;

  // Default register values after reset.
  localparam logic [WORD_W-1:0] HEADER_WORD_RST = 16'h0000;
  localparam logic [WORD_W-1:0] TAIL_WORD_RST   = 16'h0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORD   = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK     = 3'd0,
    VERDICT_SHORT  = 3'd1,
    VERDICT_HEADER = 3'd2,
    VERDICT_TAIL   = 3'd3,
    VERDICT_LENGTH = 3'd4,
    VERDICT_CRC    = 3'd5
  } verdict_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [WORD_W-1:0] payload_length;
  } frame_result_t;

  // Modbus CRC-16, one byte, reflected, LSB first.
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/cfc_frame_tracker.sv =====
// Per-frame state (count, header, length, CRC, trailing window) and verdict logic.
`timescale 1ns / 1ps

module cfc_frame_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [cfc_pkg::BYTE_W-1:0]  frame_byte,
  input  logic                        end_of_frame,
  input  logic [cfc_pkg::WORD_W-1:0]  header_word,
  input  logic [cfc_pkg::WORD_W-1:0]  tail_word,
  output cfc_pkg::frame_result_t      result
);

  logic [cfc_pkg::COUNT_W-1:0]  count_r,  count_nxt;
  logic [cfc_pkg::WORD_W-1:0]   header_r, header_nxt;
  logic [cfc_pkg::WORD_W-1:0]   length_r, length_nxt;
  logic [cfc_pkg::WORD_W-1:0]   crc_r,    crc_nxt;
  logic [cfc_pkg::WINDOW_W-1:0] win_r,    win_nxt;
  logic [cfc_pkg::COUNT_W-1:0]  expected_total;

  always_comb begin
    header_nxt = header_r;
    length_nxt = length_r;
    case (count_r)
      17'd0:   header_nxt = {frame_byte, header_r[7:0]};
      17'd1:   header_nxt = {header_r[15:8], frame_byte};
      17'd2:   length_nxt = {frame_byte, length_r[7:0]};
      17'd3:   length_nxt = {length_r[15:8], frame_byte};
      default: ;
    endcase

    // Bytes reach the CRC only after passing through the 4-byte window.
    crc_nxt   = (count_r >= cfc_pkg::FRAME_OVERHEAD)
                ? cfc_pkg::crc_byte(crc_r, win_r[31:24]) : crc_r;
    win_nxt   = {win_r[23:0], frame_byte};
    count_nxt = (count_r == cfc_pkg::COUNT_MAX) ? count_r : count_r + 17'd1;
  end

  assign expected_total = {1'b0, length_nxt} + cfc_pkg::FRAME_OVERHEAD;

  always_comb begin
    result.payload_length = length_nxt;
    if (count_nxt <= cfc_pkg::FRAME_OVERHEAD) begin
      result.verdict        = cfc_pkg::VERDICT_SHORT;
      result.payload_length = '0;
    end else if (header_nxt != header_word) begin
      result.verdict = cfc_pkg::VERDICT_HEADER;
    end else if (win_nxt[15:0] != tail_word) begin
      result.verdict = cfc_pkg::VERDICT_TAIL;
    end else if (count_nxt != expected_total) begin
      result.verdict = cfc_pkg::VERDICT_LENGTH;
    end else if (win_nxt[31:16] != crc_nxt) begin
      result.verdict = cfc_pkg::VERDICT_CRC;
    end else begin
      result.verdict = cfc_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      header_r <= '0;
      length_r <= '0;
      crc_r    <= cfc_pkg::CRC_INIT;
      win_r    <= '0;
    end else if (step) begin
      if (end_of_frame) begin
        count_r  <= '0;
        header_r <= '0;
        length_r <= '0;
        crc_r    <= cfc_pkg::CRC_INIT;
        win_r    <= '0;
      end else begin
        count_r  <= count_nxt;
        header_r <= header_nxt;
        length_r <= length_nxt;
        crc_r    <= crc_nxt;
        win_r    <= win_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/crc_frame_checker_unit.sv =====
// Top level of the CRC-16 frame checker: input register, frame tracker, result register.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one frame byte per item; in_end_of_frame marks the last byte.
//   out_* : one verdict item per frame, issued for the last byte only.
//   cfg_* : writes header_word (index 0) or tail_word (index 1); always ready.
//           Write only while no frame byte is in flight.
// Path: a last byte passes the input register and then the result register
//   before its verdict shows on out_*.
// Throughput: one byte per cycle while no last byte is held (see Stall), set by
//   the combinational CRC byte update between the input register and the frame state.
// Stall: while out_valid waits for out_ready, non-final bytes keep flowing;
//   a last byte holds in the input register and in_ready drops until the
//   pending verdict is taken.
// Reset: synchronous, active low; clears frame state, CRC to 0xFFFF, both
//   registers to zero, and empties the input and result registers.
module crc_frame_checker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cfc_pkg::BYTE_W-1:0]     in_frame_byte,
  input  logic                           in_end_of_frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cfc_pkg::VERDICT_W-1:0]  out_frame_verdict,
  output logic [cfc_pkg::WORD_W-1:0]     out_payload_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfc_pkg::WORD_W-1:0]     cfg_data
);

  logic                          in_valid_r;
  logic [cfc_pkg::BYTE_W-1:0]    in_byte_r;
  logic                          in_eof_r;
  logic                          out_valid_r;
  cfc_pkg::frame_result_t        out_result_r;
  cfc_pkg::frame_result_t        result;
  logic [cfc_pkg::WORD_W-1:0]    header_word_r;
  logic [cfc_pkg::WORD_W-1:0]    tail_word_r;
  logic                          step;

  // A non-final byte never needs the result slot.
  assign step     = in_valid_r && (!in_eof_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_word_r <= cfc_pkg::HEADER_WORD_RST;
      tail_word_r   <= cfc_pkg::TAIL_WORD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfc_pkg::REG_HEADER_WORD: header_word_r <= cfg_data;
        cfc_pkg::REG_TAIL_WORD:   tail_word_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_frame_byte;
      in_eof_r  <= in_end_of_frame;
    end
  end

  cfc_frame_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .frame_byte   (in_byte_r),
    .end_of_frame (in_eof_r),
    .header_word  (header_word_r),
    .tail_word    (tail_word_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eof_r) begin
      out_result_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_verdict  = out_result_r.verdict;
  assign out_payload_length = out_result_r.payload_length;

`ifndef SYNTHESIS
  // A new verdict only ever comes from a last byte leaving the input register.
  a_verdict_from_eof: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && in_eof_r))
    else $error("verdict issued without a last byte");

  // Backpressure only when a last byte waits behind an untaken verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && in_eof_r && out_valid_r && !out_ready))
    else $error("input stalled without a pending verdict");

  // Short frames report a zero payload length.
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_r.verdict == cfc_pkg::VERDICT_SHORT)
      |-> (out_result_r.payload_length == '0))
    else $error("short frame with nonzero length");
`endif

endmodule

// ===== dv/tb_crc_frame_checker_unit.sv =====
// Self-checking testbench for the CRC-16 frame checker: directed table, then random frames.
`timescale 1ns / 1ps

module tb_crc_frame_checker_unit;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 125;
  localparam int SETTLE      = 4;

  typedef logic [cfc_pkg::BYTE_W-1:0] frame_bytes_t[$];

  typedef struct packed {
    logic [cfc_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic                       typed;
    cfc_pkg::verdict_t          verdict;
    logic [cfc_pkg::WORD_W-1:0] plen;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [cfc_pkg::BYTE_W-1:0]    in_frame_byte;
  logic                          in_end_of_frame;
  logic                          out_valid;
  logic                          out_ready;
  logic [cfc_pkg::VERDICT_W-1:0] out_frame_verdict;
  logic [cfc_pkg::WORD_W-1:0]    out_payload_length;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cfc_pkg::WORD_W-1:0]    cfg_data;

  crc_frame_checker_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_byte      (in_frame_byte),
    .in_end_of_frame    (in_end_of_frame),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_verdict  (out_frame_verdict),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the checker's registers and frame state
  logic [cfc_pkg::WORD_W-1:0]   cfg_header;
  logic [cfc_pkg::WORD_W-1:0]   cfg_tail;
  logic [cfc_pkg::COUNT_W-1:0]  frm_count;
  logic [cfc_pkg::WORD_W-1:0]   frm_header;
  logic [cfc_pkg::WORD_W-1:0]   frm_length;
  logic [cfc_pkg::WORD_W-1:0]   frm_crc;
  logic [cfc_pkg::WINDOW_W-1:0] frm_window;

  cfc_pkg::frame_result_t verdicts_due[$];
  int                     err_count = 0;
  int                     cycle_count = 0;
  int                     tx_burst_left = 0;
  bit                     tx_steady = 1'b0;
  int                     rx_run = 0;
  logic                   rx_level = 1'b1;

  stim_row_t directed_rows [18];

  // Bit-serial form of the reflected Modbus CRC
  function automatic logic [cfc_pkg::WORD_W-1:0] modbus_crc_step(
      input logic [cfc_pkg::WORD_W-1:0] acc, input logic [cfc_pkg::BYTE_W-1:0] d);
    logic [cfc_pkg::WORD_W-1:0] c;
    c = acc;
    for (int i = 0; i < cfc_pkg::BYTE_W; i++) begin
      if (c[0] ^ d[i]) begin
        c = {1'b0, c[cfc_pkg::WORD_W-1:1]} ^ cfc_pkg::CRC_POLY;
      end else begin
        c = {1'b0, c[cfc_pkg::WORD_W-1:1]};
      end
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    frm_count  = '0;
    frm_header = '0;
    frm_length = '0;
    frm_crc    = cfc_pkg::CRC_INIT;
    frm_window = '0;
  endfunction

  // Advances the shadow frame state by one byte; returns 1 with the verdict on the last byte.
  function automatic bit track_frame_byte(input logic [cfc_pkg::BYTE_W-1:0] b,
                                          input logic last,
                                          output cfc_pkg::frame_result_t res);
    logic [cfc_pkg::COUNT_W-1:0] idx;
    idx = frm_count;
    res = '0;
    case (idx)
      17'd0: frm_header[15:8] = b;
      17'd1: frm_header[7:0]  = b;
      17'd2: frm_length[15:8] = b;
      17'd3: frm_length[7:0]  = b;
      default: ;
    endcase
    // a byte enters the CRC as it leaves the four-byte window
    if (idx >= cfc_pkg::FRAME_OVERHEAD) frm_crc = modbus_crc_step(frm_crc, frm_window[31:24]);
    frm_window = {frm_window[23:0], b};
    if (frm_count != cfc_pkg::COUNT_MAX) frm_count = frm_count + 1'b1;
    if (!last) return 1'b0;
    res.payload_length = frm_length;
    if (frm_count <= cfc_pkg::FRAME_OVERHEAD) begin
      res.verdict        = cfc_pkg::VERDICT_SHORT;
      res.payload_length = '0;
    end else if (frm_header != cfg_header) begin
      res.verdict = cfc_pkg::VERDICT_HEADER;
    end else if (frm_window[15:0] != cfg_tail) begin
      res.verdict = cfc_pkg::VERDICT_TAIL;
    end else if (frm_count != ({1'b0, frm_length} + cfc_pkg::FRAME_OVERHEAD)) begin
      res.verdict = cfc_pkg::VERDICT_LENGTH;
    end else if (frm_window[31:16] != frm_crc) begin
      res.verdict = cfc_pkg::VERDICT_CRC;
    end else begin
      res.verdict = cfc_pkg::VERDICT_OK;
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [cfc_pkg::BYTE_W-1:0] b, input logic last,
                           input logic typed, input cfc_pkg::frame_result_t typed_res);
    cfc_pkg::frame_result_t pred;
    bit                     done;
    if (tx_burst_left == 0) begin
      if (!tx_steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 24);
    end
    tx_burst_left--;
    in_valid        <= 1'b1;
    in_frame_byte   <= b;
    in_end_of_frame <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    done = track_frame_byte(b, last, pred);
    if (done) verdicts_due.push_back(typed ? typed_res : pred);
  endtask

  task automatic send_frame(input frame_bytes_t fr);
    for (int i = 0; i < fr.size(); i++) begin
      send_byte(fr[i], i == fr.size() - 1, 1'b0, '0);
    end
  endtask

  // settle must be at least 1 so in_valid is never lowered and raised in one step
  task automatic wait_verdicts_drained(input int settle);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfc_pkg::WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == cfc_pkg::REG_HEADER_WORD) begin
      cfg_header = val;
    end else begin
      cfg_tail = val;
    end
    @(posedge clk);
  endtask

  // Mostly well-formed frames, some with one flaw, a few pure noise
  function automatic frame_bytes_t build_random_frame();
    frame_bytes_t               fr;
    int                         kind;
    int                         plen;
    int                         cut;
    logic [cfc_pkg::WORD_W-1:0] crc;
    logic [cfc_pkg::BYTE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 20)) fr.push_back(8'($urandom_range(0, 255)));
      return fr;
    end
    if ($urandom_range(0, 19) == 0) begin
      plen = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      plen = $urandom_range(13, 60);
    end else begin
      plen = $urandom_range(1, 12);
    end
    crc = cfc_pkg::CRC_INIT;
    fr.push_back(cfg_header[15:8]);
    fr.push_back(cfg_header[7:0]);
    fr.push_back(8'(plen >> 8));
    fr.push_back(8'(plen));
    repeat (plen) begin
      b = 8'($urandom_range(0, 255));
      crc = modbus_crc_step(crc, b);
      fr.push_back(b);
    end
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
    fr.push_back(cfg_tail[15:8]);
    fr.push_back(cfg_tail[7:0]);
    if (kind >= 70 && plen > 0) begin
      case ($urandom_range(0, 6))
        0: fr[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        1: fr[fr.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        2: fr[$urandom_range(2, 3)] ^= 8'($urandom_range(1, 255));
        3: fr[fr.size() - 3 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        4: fr[4 + $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
        5: begin
          if ($urandom_range(0, 1)) begin
            fr.insert(4 + $urandom_range(0, plen), 8'($urandom_range(0, 255)));
          end else begin
            fr.delete(4 + $urandom_range(0, plen - 1));
          end
        end
        default: begin
          cut = $urandom_range(1, 8);
          while (fr.size() > cut) void'(fr.pop_back());
        end
      endcase
    end
    return fr;
  endfunction

  // Receiver: long ready stretches, stall runs, and choppy spells
  always @(posedge clk) begin
    if (rx_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rx_level = 1'b1;
          rx_run   = $urandom_range(20, 80);
        end
        1: begin
          rx_level = 1'b0;
          rx_run   = $urandom_range(1, 12);
        end
        default: begin
          rx_level = 1'($urandom_range(0, 1));
          rx_run   = $urandom_range(1, 4);
        end
      endcase
    end
    rx_run--;
    out_ready <= rx_level;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        if (err_count < 10) begin
          $display("unexpected verdict item: verdict %0d length %h",
                   out_frame_verdict, out_payload_length);
        end
        err_count++;
      end else begin
        cfc_pkg::frame_result_t want;
        want = verdicts_due.pop_front();
        if (out_frame_verdict !== want.verdict ||
            out_payload_length !== want.payload_length) begin
          if (err_count < 10) begin
            $display("verdict mismatch: expected %0d/%h, got %0d/%h", want.verdict,
                     want.payload_length, out_frame_verdict, out_payload_length);
          end
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[crc_frame_checker_unit] ERROR");
      $finish;
    end
  end

  initial begin
    frame_bytes_t               fr;
    int                         phase_bytes;
    logic [cfc_pkg::WORD_W-1:0] hdr;
    logic [cfc_pkg::WORD_W-1:0] tl;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_frame_byte   <= '0;
    in_end_of_frame <= 1'b0;
    out_ready       <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    cfg_header = cfc_pkg::HEADER_WORD_RST;
    cfg_tail   = cfc_pkg::TAIL_WORD_RST;
    clear_frame_state();

    directed_rows = '{
      // one-byte frame
      '{8'hFF, 1'b1, 1'b1, cfc_pkg::VERDICT_SHORT, 16'h0000},
      // eight bytes is still too short
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hFF, 1'b1, 1'b1, cfc_pkg::VERDICT_SHORT, 16'h0000},
      // smallest good frame under reset registers, one zero payload byte
      '{8'h00, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h01, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h40, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000},
      '{8'h00, 1'b1, 1'b0, cfc_pkg::VERDICT_OK, 16'h0000}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(directed_rows); i++) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                '{directed_rows[i].verdict, directed_rows[i].plen});
    end
    wait_verdicts_drained(SETTLE);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin hdr = 16'hFFFF; tl = 16'hFFFF; end
        1: begin hdr = 16'h0000; tl = 16'hFFFF; end
        2: begin hdr = 16'hFFFF; tl = 16'h0000; end
        PHASES - 1: begin hdr = 16'h0000; tl = 16'h0000; end
        default: begin
          hdr = 16'($urandom_range(0, 65535));
          tl  = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(cfc_pkg::REG_HEADER_WORD, hdr);
      write_reg(cfc_pkg::REG_TAIL_WORD, tl);
      tx_steady = ($urandom_range(0, 3) == 0);

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) wait_verdicts_drained(1);
        fr = build_random_frame();
        send_frame(fr);
        phase_bytes += fr.size();
      end
      wait_verdicts_drained(SETTLE);
    end

    wait_verdicts_drained(8);
    if (err_count == 0 && verdicts_due.size() == 0) begin
      $display("[crc_frame_checker_unit] OK");
    end else begin
      $display("[crc_frame_checker_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cfc_pkg.sv
rtl/core/cfc_frame_tracker.sv
rtl/core/crc_frame_checker_unit.sv
dv/tb_crc_frame_checker_unit.sv
